// ===== hw/rtl/ubds_pkg.sv =====
// ----------------------------------------------------------------------------
// ubds_pkg
// Shared types, constants and sizing helpers for the UART baud divisor
// search core.
// ----------------------------------------------------------------------------
package ubds_pkg;

   // default input clock of the UART being set up
   localparam int DEFAULT_CLOCK_HZ = 48000000;

   // quotient bits resolved per divider cycle
   localparam int DIV_STEP = 8;

   // smallest shift in the rate formula (prescaler 3, factor 1)
   localparam int MIN_SHIFT = 2;

   // divisor range
   localparam logic [8:0] DIV_MIN_F0 = 9'd2;
   localparam logic [8:0] DIV_MIN_F1 = 9'd9;
   localparam logic [8:0] DIV_MAX    = 9'd256;
   localparam logic [1:0] PS_MAX     = 2'd3;

   // chip version thresholds
   localparam logic [7:0] VER_BIT7_ABOVE = 8'h27;
   localparam logic [7:0] VER_LCR2_MIN   = 8'h30;

   // line control bits
   localparam logic [7:0] LCR_RX_EN   = 8'h80;
   localparam logic [7:0] LCR_TX_EN   = 8'h40;
   localparam logic [7:0] LCR_PAR_EVN = 8'h10;
   localparam logic [7:0] LCR_PAR_EN  = 8'h08;
   localparam logic [7:0] LCR_STOP2   = 8'h04;

   // flow control word when rts/cts is on
   localparam logic [8:0] FLOW_RTS_CTS = 9'd257;

   // parity and stop codes
   localparam logic [1:0] PAR_NONE = 2'd0;
   localparam logic [1:0] PAR_EVEN = 2'd1;
   localparam logic [1:0] PAR_BAD  = 2'd3;
   localparam logic [1:0] STOP_ONE = 2'd1;
   localparam logic [1:0] STOP_TWO = 2'd2;
   localparam logic [3:0] DBITS_MIN = 4'd5;
   localparam logic [3:0] DBITS_MAX = 4'd8;

   // result error codes
   typedef enum logic [2:0] {
      ERR_OK        = 3'd0,
      ERR_DATA_BITS = 3'd1,
      ERR_PARITY    = 3'd2,
      ERR_STOP_BITS = 3'd3,
      ERR_ZERO_BAUD = 3'd4
   } ubds_err_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       div_step;
      logic       div_first;
      logic       div_last;
      logic [1:0] cand_ps;
      logic       cand_fact;
      logic [8:0] cand_div;
      logic       out_load;
   } ubds_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic err_found;
      logic best_zero;
   } ubds_status_type;

   // width of the largest dividend clock_hz >> shift
   function automatic int num_width(input int clk_hz);
      return $clog2(clk_hz + 1) - MIN_SHIFT;
   endfunction

   // DIV_STEP-bit quotient groups needed to cover the largest dividend
   function automatic int div_rounds(input int clk_hz);
      return (num_width(clk_hz) + DIV_STEP - 1) / DIV_STEP;
   endfunction

endpackage

// ===== hw/rtl/uart_baud_divisor_search_core.sv =====
// ----------------------------------------------------------------------------
// uart_baud_divisor_search_core
// Turns a serial set-up request into UART divisor, line control and flow
// control words.
// ----------------------------------------------------------------------------
// One request is worked at a time. A request that fails its checks goes
// from the check state straight to the result and skips the search. A good
// request walks the candidates prescaler 0..3, factor 0..1, divisor 2 (or
// 9)..256, 2012 in all; each one goes through a divider that resolves 8
// quotient bits a cycle while the search runs. The search ends early as
// soon as some candidate hits the requested rate exactly. The result sits
// in an output register, so the next request is taken while the previous
// result waits on rsp_tready. chip_version is written through
// csr_wr_en/csr_wr_data; the user must write it only while no request is
// in flight, as the core does not enforce this.
// ----------------------------------------------------------------------------
module uart_baud_divisor_search_core import ubds_pkg::*; #(
   parameter int CLOCK_HZ = DEFAULT_CLOCK_HZ
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] baud_rate, [35:32] data_bits, [37:36] parity_mode,
   // [39:38] stop_bits, [40] rts_cts, [47:41] zero
   input  logic [47:0] req_tdata,
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] error_code, [18:3] divisor_word, [26:19] line_control,
   // [27] use_second_lcr, [36:28] flow_word, [39:37] zero
   output logic [39:0] rsp_tdata,
   // chip_version register
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   ubds_cmd_type    cmd;
   ubds_status_type status;

   logic [2:0]  error_code;
   logic [15:0] divisor_word;
   logic [7:0]  line_control;
   logic        use_second_lcr;
   logic [8:0]  flow_word;

   // sequencer
   ubds_ctrl #(
      .CLOCK_HZ (CLOCK_HZ)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // divider, compare and result words
   ubds_dpath #(
      .CLOCK_HZ (CLOCK_HZ)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .baud_rate      (req_tdata[31:0]),
      .data_bits      (req_tdata[35:32]),
      .parity_mode    (req_tdata[37:36]),
      .stop_bits      (req_tdata[39:38]),
      .rts_cts        (req_tdata[40]),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .cmd            (cmd),
      .status         (status),
      .error_code     (error_code),
      .divisor_word   (divisor_word),
      .line_control   (line_control),
      .use_second_lcr (use_second_lcr),
      .flow_word      (flow_word)
   );

   // result packing
   assign rsp_tdata = {3'd0, flow_word, use_second_lcr, line_control,
                       divisor_word, error_code};

endmodule

// ===== hw/rtl/ubds_ctrl.sv =====
// ----------------------------------------------------------------------------
// ubds_ctrl
// Request sequencing: check, candidate walk over prescaler, factor and
// divisor, divider round count and result handoff.
// ----------------------------------------------------------------------------
module ubds_ctrl import ubds_pkg::*; #(
   parameter int CLOCK_HZ = DEFAULT_CLOCK_HZ
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   input  ubds_status_type status,
   output ubds_cmd_type    cmd
);

   localparam int ROUNDS = div_rounds(CLOCK_HZ);
   localparam int RND_W  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SEARCH,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type        state_ff;
   logic [RND_W-1:0] round_ff;
   logic [1:0]       ps_ff;
   logic             fact_ff;
   logic [8:0]       div_ff;
   logic             rsp_vld_ff;

   logic last_round;
   logic last_div;
   logic last_cand;
   logic out_ready;

   // candidate bookkeeping
   assign last_round = (round_ff == RND_W'(ROUNDS - 1));
   assign last_div   = (div_ff == DIV_MAX);
   assign last_cand  = last_div & fact_ff & (ps_ff == PS_MAX);
   assign out_ready  = ~rsp_vld_ff | rsp_tready;

   // handshakes
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_vld_ff;

   // commands to the datapath
   always_comb begin
      cmd.capture   = req_tvalid & req_tready;
      cmd.div_step  = (state_ff == ST_SEARCH);
      cmd.div_first = (round_ff == '0);
      cmd.div_last  = last_round;
      cmd.cand_ps   = ps_ff;
      cmd.cand_fact = fact_ff;
      cmd.cand_div  = div_ff;
      cmd.out_load  = (state_ff == ST_FINISH) & out_ready;
   end

   // state machine and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         round_ff   <= '0;
         ps_ff      <= '0;
         fact_ff    <= 1'b0;
         div_ff     <= DIV_MIN_F0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.capture) begin
                  state_ff <= ST_CHECK;
                  round_ff <= '0;
                  ps_ff    <= '0;
                  fact_ff  <= 1'b0;
                  div_ff   <= DIV_MIN_F0;
               end
            end
            ST_CHECK: begin
               state_ff <= status.err_found ? ST_FINISH : ST_SEARCH;
            end
            ST_SEARCH: begin
               if (status.best_zero) begin
                  state_ff <= ST_FINISH;
               end else begin
                  round_ff <= last_round ? '0 : round_ff + RND_W'(1);
                  if (last_round) begin
                     if (last_cand) begin
                        state_ff <= ST_DRAIN;
                     end else if (!last_div) begin
                        div_ff <= div_ff + 9'd1;
                     end else if (!fact_ff) begin
                        fact_ff <= 1'b1;
                        div_ff  <= DIV_MIN_F1;
                     end else begin
                        ps_ff   <= ps_ff + 2'd1;
                        fact_ff <= 1'b0;
                        div_ff  <= DIV_MIN_F0;
                     end
                  end
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (out_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== hw/rtl/ubds_dpath.sv =====
// ----------------------------------------------------------------------------
// ubds_dpath
// Request fields, version register, radix-256 divider, best candidate
// tracking and the result register.
// ----------------------------------------------------------------------------
module ubds_dpath import ubds_pkg::*; #(
   parameter int CLOCK_HZ = DEFAULT_CLOCK_HZ
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [31:0]     baud_rate,
   input  logic [3:0]      data_bits,
   input  logic [1:0]      parity_mode,
   input  logic [1:0]      stop_bits,
   input  logic            rts_cts,
   input  logic            csr_wr_en,
   input  logic [7:0]      csr_wr_data,
   input  ubds_cmd_type    cmd,
   output ubds_status_type status,
   output logic [2:0]      error_code,
   output logic [15:0]     divisor_word,
   output logic [7:0]      line_control,
   output logic            use_second_lcr,
   output logic [8:0]      flow_word
);

   localparam int ROUNDS = div_rounds(CLOCK_HZ);
   localparam int DVD_W  = ROUNDS * DIV_STEP;

   // request and config
   logic [7:0]  chip_version_ff;
   logic [31:0] baud_ff;
   logic [3:0]  dbits_ff;
   logic [1:0]  par_ff;
   logic [1:0]  stop_ff;
   logic        rts_ff;

   // divider
   logic [DVD_W-1:0] dvd_ff;
   logic [8:0]       rem_ff;
   logic [DVD_W-1:0] dvd_in;
   logic [8:0]       rem_in;
   logic [3:0]       shift;
   logic [3:0]       ps_x3;
   logic [DVD_W-1:0] num_sel;

   // finished quotient waiting for compare
   logic [DVD_W-1:0] rate_ff;
   logic             rate_vld_ff;
   logic [1:0]       tag_ps_ff;
   logic             tag_fact_ff;
   logic [8:0]       tag_div_ff;

   // best so far
   logic        have_ff;
   logic [31:0] best_diff_ff;
   logic [15:0] best_word_ff;
   logic [31:0] rate32;
   logic [31:0] diff;
   logic        upd;

   ubds_err_type err;
   logic [7:0]   lcr;

   // result register
   logic [2:0]  err_out_ff;
   logic [15:0] word_out_ff;
   logic [7:0]  lcr_out_ff;
   logic        lcr2_out_ff;
   logic [8:0]  flow_out_ff;

   // dividend clock_hz >> (12 - 3*ps - fact)
   assign ps_x3   = {2'b00, cmd.cand_ps} + {1'b0, cmd.cand_ps, 1'b0};
   assign shift   = 4'd12 - ps_x3 - {3'b000, cmd.cand_fact};
   assign num_sel = DVD_W'(CLOCK_HZ >> shift);

   // eight restoring steps per cycle
   always_comb begin
      dvd_in = cmd.div_first ? num_sel : dvd_ff;
      rem_in = cmd.div_first ? 9'd0 : rem_ff;
      for (int i = 0; i < DIV_STEP; i++) begin
         rem_in = {rem_in[7:0], dvd_in[DVD_W-1]};
         dvd_in = {dvd_in[DVD_W-2:0], 1'b0};
         if (rem_in >= cmd.cand_div) begin
            rem_in    = rem_in - cmd.cand_div;
            dvd_in[0] = 1'b1;
         end
      end
   end

   // distance of the finished rate from the request
   assign rate32 = 32'(rate_ff);
   assign diff   = (rate32 > baud_ff) ? (rate32 - baud_ff) : (baud_ff - rate32);
   assign upd    = rate_vld_ff & (~have_ff | (diff < best_diff_ff));

   // request checks in priority order
   always_comb begin
      if (dbits_ff < DBITS_MIN || dbits_ff > DBITS_MAX) begin
         err = ERR_DATA_BITS;
      end else if (par_ff == PAR_BAD) begin
         err = ERR_PARITY;
      end else if (stop_ff != STOP_ONE && stop_ff != STOP_TWO) begin
         err = ERR_STOP_BITS;
      end else if (baud_ff == 32'd0) begin
         err = ERR_ZERO_BAUD;
      end else begin
         err = ERR_OK;
      end
   end

   // line control byte
   always_comb begin
      lcr = LCR_RX_EN | LCR_TX_EN | {6'd0, 2'(dbits_ff - DBITS_MIN)};
      if (par_ff != PAR_NONE) begin
         lcr = lcr | LCR_PAR_EN;
      end
      if (par_ff == PAR_EVEN) begin
         lcr = lcr | LCR_PAR_EVN;
      end
      if (stop_ff == STOP_TWO) begin
         lcr = lcr | LCR_STOP2;
      end
   end

   assign status.err_found = (err != ERR_OK);
   assign status.best_zero = have_ff & (best_diff_ff == 32'd0);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         chip_version_ff <= '0;
         rate_vld_ff     <= 1'b0;
         have_ff         <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            chip_version_ff <= csr_wr_data;
         end
         rate_vld_ff <= ~cmd.capture & cmd.div_step & cmd.div_last;
         if (cmd.capture) begin
            have_ff <= 1'b0;
         end else if (upd) begin
            have_ff <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         baud_ff  <= baud_rate;
         dbits_ff <= data_bits;
         par_ff   <= parity_mode;
         stop_ff  <= stop_bits;
         rts_ff   <= rts_cts;
      end
      if (cmd.div_step) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
      if (cmd.div_step & cmd.div_last) begin
         rate_ff     <= dvd_in;
         tag_ps_ff   <= cmd.cand_ps;
         tag_fact_ff <= cmd.cand_fact;
         tag_div_ff  <= cmd.cand_div;
      end
      if (upd) begin
         best_diff_ff <= diff;
         best_word_ff <= {8'(DIV_MAX - tag_div_ff), 5'd0, tag_fact_ff, tag_ps_ff};
      end
      if (cmd.out_load) begin
         err_out_ff <= err;
         if (err != ERR_OK) begin
            word_out_ff <= '0;
            lcr_out_ff  <= '0;
            lcr2_out_ff <= 1'b0;
            flow_out_ff <= '0;
         end else begin
            word_out_ff <= best_word_ff
                         | {8'd0, (chip_version_ff > VER_BIT7_ABOVE), 7'd0};
            lcr_out_ff  <= lcr;
            lcr2_out_ff <= (chip_version_ff >= VER_LCR2_MIN);
            flow_out_ff <= rts_ff ? FLOW_RTS_CTS : 9'd0;
         end
      end
   end

   assign error_code     = err_out_ff;
   assign divisor_word   = word_out_ff;
   assign line_control   = lcr_out_ff;
   assign use_second_lcr = lcr2_out_ff;
   assign flow_word      = flow_out_ff;

endmodule

// ===== test/uart_baud_divisor_search_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_baud_divisor_search_core_tb
// Self-checking bench for the UART baud divisor search core.
// ----------------------------------------------------------------------------
// Set-up requests go in on the req_ stream and results come back on the rsp_
// stream. A scoreboard predicts every result: it walks the prescaler,
// factor and divisor candidates itself and applies the field checks, the
// line-control encoding and the chip version rules. Each returned result is
// compared field by field against the oldest prediction. A short directed
// set hits the rate extremes, every error and its priority. Random phases
// follow, each run after a chip version write, mostly with well-formed
// requests and some noise. Random idle bursts hit both streams, except in
// the final phase.
// ----------------------------------------------------------------------------
module uart_baud_divisor_search_core_tb;
   import ubds_pkg::*;

   localparam int          NUM_PHASES      = 7;
   localparam int          ITEMS_PER_PHASE = 17;
   localparam int          WATCHDOG_LIMIT  = 60000;
   localparam int          TOP_SHIFT       = 12;
   localparam logic [1:0]  PAR_ODD         = 2'd2;
   localparam logic [1:0]  STOP_NONE       = 2'd0;
   localparam logic [1:0]  STOP_BAD        = 2'd3;

   typedef struct packed {
      logic [31:0] baud;
      logic [3:0]  dbits;
      logic [1:0]  parity;
      logic [1:0]  stop;
      logic        rts;
   } setup_req_type;

   typedef struct packed {
      ubds_err_type err;
      logic [15:0]  divisor_word;
      logic [7:0]   line_control;
      logic         second_lcr;
      logic [8:0]   flow_word;
   } setup_rsp_type;

   // scoreboard: predicts set-up words and checks returned results
   class setup_checker;
      int unsigned   clock_hz;
      logic [7:0]    version;
      setup_rsp_type expected_words[$];
      int            errors;
      int            checked;
      int            rejected;

      function new(int unsigned hz);
         clock_hz = hz;
         version  = '0;
         errors   = 0;
         checked  = 0;
         rejected = 0;
      endfunction

      task report(string msg);
         $display("ERROR at %0t: %s", $realtime, msg);
         errors++;
      endtask

      function int pending();
         return expected_words.size();
      endfunction

      // first candidate with the smallest rate error wins
      function logic [15:0] nearest_divisor_word(logic [31:0] baud);
         logic [31:0]     best_gap;
         logic [31:0]     gap;
         logic [31:0]     rate;
         logic [15:0]     best;
         longint unsigned den;
         int              lo;
         bit              first;
         best_gap = '1;
         best     = '0;
         first    = 1'b1;
         for (int ps = 0; ps <= PS_MAX; ps++) begin
            for (int fact = 0; fact <= 1; fact++) begin
               lo = fact ? DIV_MIN_F1 : DIV_MIN_F0;
               for (int d = lo; d <= DIV_MAX; d++) begin
                  den  = (64'd1 << (TOP_SHIFT - 3 * ps - fact)) * 64'(d);
                  rate = 32'(64'(clock_hz) / den);
                  gap  = (rate > baud) ? rate - baud : baud - rate;
                  if (first || gap < best_gap) begin
                     first    = 1'b0;
                     best_gap = gap;
                     best     = {8'(256 - d), 5'd0, 1'(fact), 2'(ps)};
                  end
                  if (best_gap == 0) return best;
               end
            end
         end
         return best;
      endfunction

      function setup_rsp_type predict_setup_words(setup_req_type r);
         setup_rsp_type p;
         p = '0;
         if (r.dbits < DBITS_MIN || r.dbits > DBITS_MAX) begin
            p.err = ERR_DATA_BITS;
         end else if (r.parity == PAR_BAD) begin
            p.err = ERR_PARITY;
         end else if (r.stop != STOP_ONE && r.stop != STOP_TWO) begin
            p.err = ERR_STOP_BITS;
         end else if (r.baud == 0) begin
            p.err = ERR_ZERO_BAUD;
         end else begin
            p.err          = ERR_OK;
            p.line_control = LCR_RX_EN | LCR_TX_EN | {4'd0, r.dbits - DBITS_MIN};
            if (r.parity != PAR_NONE) p.line_control |= LCR_PAR_EN;
            if (r.parity == PAR_EVEN) p.line_control |= LCR_PAR_EVN;
            if (r.stop == STOP_TWO)   p.line_control |= LCR_STOP2;
            p.divisor_word = nearest_divisor_word(r.baud);
            if (version > VER_BIT7_ABOVE) p.divisor_word |= 16'h0080;
            p.second_lcr = (version >= VER_LCR2_MIN);
            p.flow_word  = r.rts ? FLOW_RTS_CTS : 9'd0;
         end
         return p;
      endfunction

      function void note_request(setup_req_type r);
         expected_words.push_back(predict_setup_words(r));
      endfunction

      task check_result(logic [39:0] data);
         setup_rsp_type got;
         setup_rsp_type want;
         got.err          = ubds_err_type'(data[2:0]);
         got.divisor_word = data[18:3];
         got.line_control = data[26:19];
         got.second_lcr   = data[27];
         got.flow_word    = data[36:28];
         if (expected_words.size() == 0) begin
            report($sformatf("result %h with no request pending", data));
            return;
         end
         want = expected_words.pop_front();
         checked++;
         if (want.err != ERR_OK) rejected++;
         if (got.err !== want.err)
            report($sformatf("result %0d error_code %0d, want %0d", checked, got.err, want.err));
         if (got.divisor_word !== want.divisor_word)
            report($sformatf("result %0d divisor_word %h, want %h",
                             checked, got.divisor_word, want.divisor_word));
         if (got.line_control !== want.line_control)
            report($sformatf("result %0d line_control %h, want %h",
                             checked, got.line_control, want.line_control));
         if (got.second_lcr !== want.second_lcr)
            report($sformatf("result %0d use_second_lcr %b, want %b",
                             checked, got.second_lcr, want.second_lcr));
         if (got.flow_word !== want.flow_word)
            report($sformatf("result %0d flow_word %0d, want %0d",
                             checked, got.flow_word, want.flow_word));
      endtask

      task report_missing();
         while (expected_words.size() != 0) begin
            void'(expected_words.pop_front());
            report("expected result never came out");
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;

   bit           quiet = 1'b0;
   int           stalled_cycles = 0;
   setup_checker book = new(DEFAULT_CLOCK_HZ);

   uart_baud_divisor_search_core #(
      .CLOCK_HZ (DEFAULT_CLOCK_HZ)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // push one set-up request, with an occasional idle burst ahead of it
   task automatic send_setup(input logic [31:0] baud, input logic [3:0] dbits,
                             input logic [1:0] parity, input logic [1:0] stop,
                             input logic rts);
      setup_req_type r;
      r.baud   = baud;
      r.dbits  = dbits;
      r.parity = parity;
      r.stop   = stop;
      r.rts    = rts;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, rts, stop, parity, dbits, baud};
      do @(posedge clock); while (req_tready !== 1'b1);
      book.note_request(r);
   endtask

   // wait until every pending result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
   endtask

   // baud rates: standard, ranged, full width, tiny, or exact candidates
   function automatic logic [31:0] random_baud();
      logic [31:0] std_rates [15] = '{300, 1200, 2400, 4800, 9600, 19200, 38400,
                                      57600, 115200, 230400, 460800, 921600,
                                      1000000, 1500000, 3000000};
      int ps;
      int fact;
      int d;
      case ($urandom_range(0, 4))
         0: return std_rates[$urandom_range(0, 14)];
         1: return $urandom_range(1, 3000000);
         2: return $urandom;
         3: return $urandom_range(1, 2000);
         default: begin
            ps   = $urandom_range(0, PS_MAX);
            fact = $urandom_range(0, 1);
            d    = $urandom_range(fact ? DIV_MIN_F1 : DIV_MIN_F0, DIV_MAX);
            return 32'(64'(DEFAULT_CLOCK_HZ) /
                       ((64'd1 << (TOP_SHIFT - 3 * ps - fact)) * 64'(d)));
         end
      endcase
   endfunction

   // result side: random stall bursts, checks on every accepted result
   initial begin
      int hold;
      hold = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready) book.check_result(rsp_tdata);
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 15) == 0) begin
            hold = $urandom_range(1, 13) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on cycles where neither stream moves
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stalled_cycles = 0;
      else
         stalled_cycles++;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // main sequence
   initial begin
      logic [7:0] ver;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      reset       <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed set under the reset chip version
      send_setup(32'd115200,   4'd8,  PAR_NONE, STOP_ONE,  1'b0);
      send_setup(32'd9600,     4'd7,  PAR_EVEN, STOP_TWO,  1'b1);
      send_setup(32'd3000000,  4'd5,  PAR_ODD,  STOP_ONE,  1'b0);
      send_setup(32'd1,        4'd6,  PAR_EVEN, STOP_ONE,  1'b1);
      send_setup(32'hFFFFFFFF, 4'd8,  PAR_ODD,  STOP_TWO,  1'b1);
      send_setup(32'd22,       4'd5,  PAR_NONE, STOP_TWO,  1'b0);
      send_setup(32'd1333333,  4'd8,  PAR_NONE, STOP_ONE,  1'b1);
      send_setup(32'd2000000,  4'd6,  PAR_ODD,  STOP_TWO,  1'b0);
      send_setup(32'd0,        4'd8,  PAR_NONE, STOP_ONE,  1'b1);
      send_setup(32'd115200,   4'd4,  PAR_NONE, STOP_ONE,  1'b0);
      send_setup(32'd115200,   4'd9,  PAR_EVEN, STOP_TWO,  1'b1);
      send_setup(32'd115200,   4'd0,  PAR_NONE, STOP_ONE,  1'b0);
      send_setup(32'hFFFFFFFF, 4'd15, PAR_BAD,  STOP_BAD,  1'b1);
      send_setup(32'd9600,     4'd8,  PAR_BAD,  STOP_NONE, 1'b0);
      send_setup(32'd9600,     4'd5,  PAR_BAD,  STOP_ONE,  1'b1);
      send_setup(32'd9600,     4'd8,  PAR_NONE, STOP_NONE, 1'b0);
      send_setup(32'd9600,     4'd6,  PAR_ODD,  STOP_BAD,  1'b1);
      send_setup(32'd0,        4'd8,  PAR_EVEN, STOP_BAD,  1'b0);
      send_setup(32'd0,        4'd4,  PAR_BAD,  STOP_NONE, 1'b1);
      drain();

      // random phases, each after a chip version write
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: ver = VER_BIT7_ABOVE;
            1: ver = VER_BIT7_ABOVE + 8'd1;
            2: ver = VER_LCR2_MIN - 8'd1;
            3: ver = VER_LCR2_MIN;
            4: ver = 8'hFF;
            5: ver = 8'h00;
            default: ver = 8'($urandom_range(0, 255));
         endcase
         quiet = (p == NUM_PHASES - 1);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= ver;
         @(posedge clock);
         csr_wr_en   <= 1'b0;
         book.version = ver;
         repeat (ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 9) < 7)
               send_setup(random_baud(), 4'($urandom_range(DBITS_MIN, DBITS_MAX)),
                          2'($urandom_range(0, 2)), 2'($urandom_range(1, 2)),
                          1'($urandom_range(0, 1)));
            else
               send_setup(($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom),
                          4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                          2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         end
         drain();
      end

      // catch any stray result, then settle
      repeat (64) @(posedge clock);
      book.report_missing();
      $display("checked %0d set-up requests, %0d of them rejected by the field checks",
               book.checked, book.rejected);
      $display("chip version went through %0d settings around both thresholds and the extremes",
               NUM_PHASES + 1);
      if (book.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
